>>> hdl/tlam_pkg.sv
package tlam_pkg;

    localparam int PULSE_W   = 26;
    localparam int SPEED_W   = 19;
    localparam int COUNT_W   = 7;
    localparam int LEVEL_W   = 18;
    localparam int REPEAT_W  = 4;
    localparam int SUM_W     = 24;
    localparam int PRODUCT_W = PULSE_W + SPEED_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = SPEED_W;
    localparam int BATCH_W   = 9;

    localparam int MAX_BATCH_DEFAULT = 64;

    // Distance divide: product / (2e10 / 256), quotient needs 19 bits
    localparam int DIST_Q_W  = 19;
    localparam int DIV_REM_W = 27;
    localparam int DIV_NUM_W = SUM_W;
    localparam int DIV_CNT_W = 5;

    localparam logic [DIV_REM_W-1:0] DIST_DIVISOR = 27'd78125000;
    localparam logic [PULSE_W-1:0]   PULSE_MAX    = 26'd40000000;
    localparam logic [LEVEL_W-1:0]   DIST_MAX     = 18'h3FFFF;
    localparam logic [SUM_W-1:0]     SUM_MAX      = 24'hFFFFFF;

    localparam logic [DIV_CNT_W-1:0] DIST_STEPS = 5'd19;
    localparam logic [DIV_CNT_W-1:0] AVG_STEPS  = 5'd24;

    localparam logic [SPEED_W-1:0]  SPEED_RESET  = 19'd340290;
    localparam logic [COUNT_W-1:0]  COUNT_RESET  = 7'd30;
    localparam logic [LEVEL_W-1:0]  LEVEL_RESET  = 18'd1766;
    localparam logic [REPEAT_W-1:0] REPEAT_RESET = 4'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SPEED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT = 2'd3;

    typedef struct packed {
        logic                 start;
        logic [DIV_REM_W-1:0] rem_init;
        logic [DIV_NUM_W-1:0] num_init;
        logic [DIV_REM_W-1:0] divisor;
        logic [DIV_CNT_W-1:0] steps;
    } div_load_t;

endpackage

>>> hdl/tlam_mul.sv
module tlam_mul
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [tlam_pkg::PULSE_W-1:0]      a,
    input  logic [tlam_pkg::SPEED_W-1:0]      b,
    output logic                              done,
    output logic [tlam_pkg::PRODUCT_W-1:0]    product
);

    localparam int A_W   = tlam_pkg::PULSE_W;
    localparam int B_W   = tlam_pkg::SPEED_W;
    localparam int P_W   = tlam_pkg::PRODUCT_W;
    localparam int CNT_W = $clog2(A_W + 1);

    logic [P_W-1:0]   acc_reg, acc_next;
    logic [A_W-1:0]   a_reg, a_next;
    logic [B_W-1:0]   b_reg, b_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [B_W:0]     sum_hi;

    // One multiplier bit per cycle, LSB first; accumulator shifts right
    assign sum_hi = {1'b0, acc_reg[P_W-1:A_W]} + (a_reg[0] ? {1'b0, b_reg} : '0);

    always_comb
    begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg)
        begin
            acc_next = {sum_hi, acc_reg[A_W-1:1]};
            a_next   = a_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            acc_next  = '0;
            a_next    = a;
            b_next    = b;
            cnt_next  = CNT_W'(A_W);
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

>>> hdl/tlam_div.sv
module tlam_div
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  tlam_pkg::div_load_t               load,
    output logic                              done,
    output logic [tlam_pkg::DIV_NUM_W-1:0]    quotient
);

    localparam int R_W = tlam_pkg::DIV_REM_W;
    localparam int N_W = tlam_pkg::DIV_NUM_W;
    localparam int C_W = tlam_pkg::DIV_CNT_W;

    logic [R_W-1:0] rem_reg, rem_next;
    logic [N_W-1:0] num_reg, num_next;
    logic [N_W-1:0] quo_reg, quo_next;
    logic [R_W-1:0] dvs_reg, dvs_next;
    logic [C_W-1:0] cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [R_W:0]   shifted;
    logic [R_W:0]   diff;

    // Restoring division, one quotient bit per cycle
    assign shifted = {rem_reg, num_reg[N_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg)
        begin
            if (!diff[R_W])
            begin
                rem_next = diff[R_W-1:0];
                quo_next = {quo_reg[N_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[R_W-1:0];
                quo_next = {quo_reg[N_W-2:0], 1'b0};
            end
            num_next = num_reg << 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == C_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (load.start)
        begin
            rem_next  = load.rem_init;
            num_next  = load.num_init;
            quo_next  = '0;
            dvs_next  = load.divisor;
            cnt_next  = load.steps;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> hdl/tank_level_alarm_monitor.sv
// Channel  | Direction | Handshake                   | Payload
// pulse    | in        | pulse_valid / pulse_ready   | pulse_ns
// result   | out       | result_valid / result_ready | average_q8, above_level, refill, high_runs
// cfg      | in        | cfg_we                      | cfg_index, cfg_data
//
// A read is summed once it has passed the shift-add multiplier and then the 19-bit
// distance divide in the shared restoring divider; the next request follows.
// A read that closes a batch then goes through a 24-bit average divide and write-back.
// Reset clears the batch sum, read count, high-batch run and result valid.
// A waiting result holds in the output register; a closing read stalls there only
// while the previous result is still untaken.
module tank_level_alarm_monitor
#(
    parameter int MAX_BATCH = tlam_pkg::MAX_BATCH_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [tlam_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tlam_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              pulse_valid,
    output logic                              pulse_ready,
    input  logic [tlam_pkg::PULSE_W-1:0]      pulse_ns,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic [tlam_pkg::LEVEL_W-1:0]      average_q8,
    output logic                              above_level,
    output logic                              refill,
    output logic [tlam_pkg::REPEAT_W-1:0]     high_runs
);

    localparam int SUM_W    = tlam_pkg::SUM_W;
    localparam int COUNT_W  = tlam_pkg::COUNT_W;
    localparam int LEVEL_W  = tlam_pkg::LEVEL_W;
    localparam int REPEAT_W = tlam_pkg::REPEAT_W;
    localparam int BATCH_W  = tlam_pkg::BATCH_W;
    localparam int Q_W      = tlam_pkg::DIST_Q_W;
    localparam int P_W      = tlam_pkg::PRODUCT_W;
    localparam int N_W      = tlam_pkg::DIV_NUM_W;
    localparam int R_W      = tlam_pkg::DIV_REM_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_DDIV = 5'b00100,
        S_ADIV = 5'b01000,
        S_WB   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [tlam_pkg::SPEED_W-1:0] speed_reg;
    logic [COUNT_W-1:0]           count_reg;
    logic [LEVEL_W-1:0]           level_reg;
    logic [REPEAT_W-1:0]          repeat_reg;

    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [COUNT_W-1:0]  taken_reg, taken_next;
    logic [REPEAT_W-1:0] run_reg, run_next;

    logic                res_valid_reg, res_valid_next;
    logic [LEVEL_W-1:0]  res_avg_reg, res_avg_next;
    logic                res_above_reg, res_above_next;
    logic                res_refill_reg, res_refill_next;
    logic [REPEAT_W-1:0] res_runs_reg, res_runs_next;

    logic                          mul_start;
    logic                          mul_done;
    logic [tlam_pkg::PULSE_W-1:0]  pulse_clamped;
    logic [P_W-1:0]                product;
    tlam_pkg::div_load_t           div_load;
    logic                          div_done;
    logic [N_W-1:0]                quotient;

    logic [COUNT_W-1:0]  n_base;
    logic [COUNT_W-1:0]  n_eff;
    logic [REPEAT_W-1:0] rep_eff;
    logic [LEVEL_W-1:0]  read_dist;
    logic [SUM_W:0]      sum_wide;
    logic [SUM_W-1:0]    sum_sat;
    logic [COUNT_W-1:0]  taken_inc;
    logic                batch_done;
    logic [LEVEL_W-1:0]  avg;
    logic                above;
    logic [REPEAT_W-1:0] run_inc;
    logic                refill_hit;
    logic                slot_free;

    assign pulse_clamped = (pulse_ns > tlam_pkg::PULSE_MAX) ? tlam_pkg::PULSE_MAX : pulse_ns;

    tlam_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (pulse_clamped),
        .b       (speed_reg),
        .done    (mul_done),
        .product (product)
    );

    tlam_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (div_load),
        .done     (div_done),
        .quotient (quotient)
    );

    // Effective batch size and repeat
    always_comb
    begin
        n_base = (count_reg == '0) ? COUNT_W'(1) : count_reg;
        if (BATCH_W'(MAX_BATCH) < {{(BATCH_W-COUNT_W){1'b0}}, n_base})
            n_eff = COUNT_W'(MAX_BATCH);
        else
            n_eff = n_base;
        rep_eff = (repeat_reg == '0) ? REPEAT_W'(1) : repeat_reg;
    end

    // Distance from the shared divider, saturated
    assign read_dist  = quotient[Q_W-1] ? tlam_pkg::DIST_MAX : quotient[LEVEL_W-1:0];
    assign sum_wide   = {1'b0, sum_reg} + {{(SUM_W+1-LEVEL_W){1'b0}}, read_dist};
    assign sum_sat    = sum_wide[SUM_W] ? tlam_pkg::SUM_MAX : sum_wide[SUM_W-1:0];
    assign taken_inc  = taken_reg + 1'b1;
    assign batch_done = (taken_inc >= n_eff) || (taken_inc == '0);

    // Average, saturated, and the run update
    assign avg        = (|quotient[N_W-1:LEVEL_W]) ? tlam_pkg::DIST_MAX
                                                   : quotient[LEVEL_W-1:0];
    assign above      = avg > level_reg;
    assign run_inc    = above ? (run_reg + 1'b1) : '0;
    assign refill_hit = run_inc >= rep_eff;
    assign slot_free  = !res_valid_reg || result_ready;

    assign pulse_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        sum_next        = sum_reg;
        taken_next      = taken_reg;
        run_next        = run_reg;
        res_valid_next  = res_valid_reg && !result_ready;
        res_avg_next    = res_avg_reg;
        res_above_next  = res_above_reg;
        res_refill_next = res_refill_reg;
        res_runs_next   = res_runs_reg;
        mul_start       = 1'b0;
        div_load.start    = 1'b0;
        div_load.rem_init = {1'b0, product[P_W-1:Q_W]};
        div_load.num_init = {product[Q_W-1:0], {(N_W-Q_W){1'b0}}};
        div_load.divisor  = tlam_pkg::DIST_DIVISOR;
        div_load.steps    = tlam_pkg::DIST_STEPS;
        case (state_reg)
            S_IDLE:
            begin
                if (pulse_valid)
                begin
                    mul_start  = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    div_load.start = 1'b1;
                    state_next     = S_DDIV;
                end
            end
            S_DDIV:
            begin
                if (div_done)
                begin
                    if (batch_done)
                    begin
                        // Close the batch: divide the sum by the batch size
                        sum_next          = '0;
                        taken_next        = '0;
                        div_load.start    = 1'b1;
                        div_load.rem_init = '0;
                        div_load.num_init = sum_sat;
                        div_load.divisor  = {{(R_W-COUNT_W){1'b0}}, n_eff};
                        div_load.steps    = tlam_pkg::AVG_STEPS;
                        state_next        = S_ADIV;
                    end
                    else
                    begin
                        sum_next   = sum_sat;
                        taken_next = taken_inc;
                        state_next = S_IDLE;
                    end
                end
            end
            S_ADIV:
            begin
                if (div_done)
                    state_next = S_WB;
            end
            S_WB:
            begin
                // Hold the result until the output register is free
                if (slot_free)
                begin
                    run_next        = refill_hit ? '0 : run_inc;
                    res_valid_next  = 1'b1;
                    res_avg_next    = avg;
                    res_above_next  = above;
                    res_refill_next = refill_hit;
                    res_runs_next   = refill_hit ? '0 : run_inc;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sum_reg       <= '0;
            taken_reg     <= '0;
            run_reg       <= '0;
            res_valid_reg <= 1'b0;
            speed_reg     <= tlam_pkg::SPEED_RESET;
            count_reg     <= tlam_pkg::COUNT_RESET;
            level_reg     <= tlam_pkg::LEVEL_RESET;
            repeat_reg    <= tlam_pkg::REPEAT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            taken_reg     <= taken_next;
            run_reg       <= run_next;
            res_valid_reg <= res_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    tlam_pkg::CFG_SPEED:  speed_reg  <= cfg_data;
                    tlam_pkg::CFG_COUNT:  count_reg  <= cfg_data[COUNT_W-1:0];
                    tlam_pkg::CFG_LEVEL:  level_reg  <= cfg_data[LEVEL_W-1:0];
                    tlam_pkg::CFG_REPEAT: repeat_reg <= cfg_data[REPEAT_W-1:0];
                    default:              ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_avg_reg    <= res_avg_next;
        res_above_reg  <= res_above_next;
        res_refill_reg <= res_refill_next;
        res_runs_reg   <= res_runs_next;
    end

    assign result_valid = res_valid_reg;
    assign average_q8   = res_avg_reg;
    assign above_level  = res_above_reg;
    assign refill       = res_refill_reg;
    assign high_runs    = res_runs_reg;

endmodule
